// File: hw/rtl/atdc_pkg.sv
// Shared types, constants and codes for the arrival time difference capture block.
package atdc_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int TIME_BITS_DEF = 32;

    localparam int PIN_W   = 8;
    localparam int NOW_W   = 32;
    localparam int DELAY_W = 32;
    localparam int CHAN_W  = 3;
    localparam int MASK_W  = 8;
    localparam int CFG_W   = 32;
    localparam int CNTC_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNTC_W-1:0] CHANNELS_RESET = 4'd8;
    localparam logic [CFG_W-1:0]  TIMEOUT_RESET  = 32'd500000;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_CHECK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [PIN_W-1:0] pin_levels;
        logic [NOW_W-1:0] now_us;
    } t_in;

    typedef struct packed {
        logic               all_triggered;
        logic [CHAN_W-1:0]  channel;
        logic [DELAY_W-1:0] delay_us;
        logic [MASK_W-1:0]  expired_mask;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic sample;
        logic clear;
        logic check_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic emit_done;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/atdc_ctrl.sv
// Controller state machine: item decode, channel scan and result emission sequencing.
module atdc_ctrl
    import atdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    output t_cmd       o_cmd,
    input  t_status    i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_func)
                        FUNC_SAMPLE: o_cmd.sample = 1'b1;
                        FUNC_CLEAR:  o_cmd.clear  = 1'b1;
                        FUNC_CHECK: begin
                            o_cmd.check_start = 1'b1;
                            n_state           = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/atdc_datapath.sv
// Datapath: capture registers, age and earliest-arrival scan, delay and output register.
module atdc_datapath
    import atdc_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in                  i_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(CHANNELS + 1);
    localparam int CN_W   = (CNT_W > CNTC_W) ? CNT_W : CNTC_W;
    localparam int CMP_W  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int RISE_W = (CHANNELS > PIN_W) ? CHANNELS : PIN_W;

    logic [CNTC_W-1:0]    r_chan_cfg;
    logic [CFG_W-1:0]     r_timeout;
    logic [TIME_BITS-1:0] r_time [CHANNELS];
    logic [CHANNELS-1:0]  r_flag;
    logic [PIN_W-1:0]     r_prev;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_earliest;
    logic [CHANNELS-1:0]  r_expired;
    logic                 r_all;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [CN_W-1:0]      cfg_ext;
    logic [CNT_W-1:0]     n_act;
    logic [RISE_W-1:0]    rising;
    logic [TIME_BITS-1:0] cur_time;
    logic [TIME_BITS-1:0] age;
    logic                 expire;
    logic                 idx_last;
    logic                 out_free;

    // clamp the configured channel count into 1..CHANNELS
    always_comb begin
        cfg_ext = CN_W'(r_chan_cfg);
        if (cfg_ext == '0) begin
            n_act = CNT_W'(1);
        end else if (cfg_ext > CN_W'(CHANNELS)) begin
            n_act = CNT_W'(CHANNELS);
        end else begin
            n_act = CNT_W'(cfg_ext);
        end
    end

    assign rising   = RISE_W'(i_in.pin_levels & ~r_prev);
    assign cur_time = r_time[r_idx];
    assign age      = r_now - cur_time;
    assign expire   = r_flag[r_idx] && (CMP_W'(age) > CMP_W'(r_timeout));
    assign idx_last = (CNT_W'(r_idx) + CNT_W'(1)) == n_act;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.idx_last  = idx_last;
    assign o_status.emit_done = !r_all || idx_last;
    assign o_status.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cfg <= CHANNELS_RESET;
            r_timeout  <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHANNELS: r_chan_cfg <= i_cfg_data[CNTC_W-1:0];
                REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture flags and previous levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            r_prev <= '0;
        end else begin
            if (i_cmd.sample) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (rising[i] && !r_flag[i] && (CNT_W'(i) < n_act)) begin
                        r_flag[i] <= 1'b1;
                    end
                end
                r_prev <= i_in.pin_levels;
            end
            if (i_cmd.clear) begin
                r_flag <= '0;
            end
            if (i_cmd.scan_step && expire) begin
                r_flag[r_idx] <= 1'b0;
            end
        end
    end

    // timestamps are only read behind a set flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (rising[i] && !r_flag[i] && (CNT_W'(i) < n_act)) begin
                    r_time[i] <= TIME_BITS'(i_in.now_us);
                end
            end
        end
    end

    // scan and emission bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.check_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step || i_cmd.emit) begin
            r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check_start) begin
            r_now      <= TIME_BITS'(i_in.now_us);
            r_earliest <= '1;
            r_expired  <= '0;
            r_all      <= 1'b1;
        end else if (i_cmd.scan_step) begin
            if (expire) begin
                r_expired[r_idx] <= 1'b1;
                r_all            <= 1'b0;
            end else if (!r_flag[r_idx]) begin
                r_all <= 1'b0;
            end else if (cur_time < r_earliest) begin
                r_earliest <= cur_time;
            end
        end
    end

    // output register: load a beat when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.expired_mask <= MASK_W'(r_expired);
            if (r_all) begin
                r_out.all_triggered <= 1'b1;
                r_out.channel       <= CHAN_W'(r_idx);
                r_out.delay_us      <= DELAY_W'(cur_time - r_earliest);
                r_out.last          <= idx_last;
            end else begin
                r_out.all_triggered <= 1'b0;
                r_out.channel       <= '0;
                r_out.delay_us      <= '0;
                r_out.last          <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded over an untaken beat");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step || i_cmd.emit) |-> (CNT_W'(r_idx) < n_act))
        else $error("channel index beyond channels in use");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_all) |=> (o_out_valid && o_out.last && !o_out.all_triggered))
        else $error("not-triggered result must be a single last beat");

    a_trig_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_all) |-> (r_expired == '0))
        else $error("triggered check with expired captures");

endmodule

// File: hw/rtl/arrival_time_difference_capture.sv
// Top level of the arrival time difference capture block.
// Keeps a first-rising-edge timestamp per channel. Sample and clear items complete when
// accepted and the next item is accepted in the following cycle. A check item walks the
// channels in use through one shared age comparator, one channel per cycle, then loads
// one result per cycle, while the output register is free, into the single output register:
// one result per channel in use when every one of them holds a live capture, otherwise one.
// The next item is accepted the cycle after the last result is loaded. A result waiting in
// the output register does not block the input.
module arrival_time_difference_capture
    import atdc_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    atdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    atdc_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the arrival time difference capture block: directed and random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atdc_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int RANDOM_ITEMS  = 240;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_beat   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_beat;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int          in_idle_pct  = 14;
    int          out_idle_pct = 14;
    int          fail_cnt     = 0;
    int unsigned cycle_cnt    = 0;

    // Predicted capture state and register copies
    logic [CNTC_W-1:0] cfg_channels = CHANNELS_RESET;
    logic [CFG_W-1:0]  cfg_timeout  = TIMEOUT_RESET;
    logic [NOW_W-1:0]  arrival_time [CHANNELS_DEF] = '{default: '0};
    logic              arrival_held [CHANNELS_DEF] = '{default: 1'b0};
    logic [PIN_W-1:0]  last_levels  = '0;
    t_out              delay_reports [$];

    arrival_time_difference_capture uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic int unsigned channels_active();
        int unsigned n;
        n = 32'(cfg_channels);
        if (n == 0) n = 1;
        if (n > CHANNELS_DEF) n = CHANNELS_DEF;
        return n;
    endfunction

    task automatic apply_capture_item(input t_in item);
        int unsigned       n;
        logic [PIN_W-1:0]  rising;
        logic [MASK_W-1:0] expired;
        logic              all_live;
        logic [NOW_W-1:0]  earliest;
        logic [NOW_W-1:0]  age;
        t_out              rep;
        n = channels_active();
        case (item.func)
            FUNC_SAMPLE: begin
                rising = item.pin_levels & ~last_levels;
                for (int i = 0; i < n; i++) begin
                    if (rising[i] && !arrival_held[i]) begin
                        arrival_time[i] = item.now_us;
                        arrival_held[i] = 1'b1;
                    end
                end
                // unused channels still update the level history
                last_levels = item.pin_levels;
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < CHANNELS_DEF; i++) begin
                    arrival_time[i] = '0;
                    arrival_held[i] = 1'b0;
                end
            end
            FUNC_CHECK: begin
                expired  = '0;
                all_live = 1'b1;
                for (int i = 0; i < n; i++) begin
                    age = item.now_us - arrival_time[i];
                    if (arrival_held[i] && age > cfg_timeout) begin
                        arrival_time[i] = '0;
                        arrival_held[i] = 1'b0;
                        expired[i]      = 1'b1;
                    end
                    if (!arrival_held[i]) all_live = 1'b0;
                end
                if (!all_live) begin
                    rep              = '0;
                    rep.expired_mask = expired;
                    rep.last         = 1'b1;
                    delay_reports.push_back(rep);
                end else begin
                    // plain unsigned minimum, not wrapping order
                    earliest = arrival_time[0];
                    for (int i = 1; i < n; i++) begin
                        if (arrival_time[i] < earliest) earliest = arrival_time[i];
                    end
                    for (int i = 0; i < n; i++) begin
                        rep.all_triggered = 1'b1;
                        rep.channel       = CHAN_W'(i);
                        rep.delay_us      = arrival_time[i] - earliest;
                        rep.expired_mask  = expired;
                        rep.last          = (i == n - 1);
                        delay_reports.push_back(rep);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (delay_reports.size() == 0) begin
                $error("result beat with nothing expected: channel %0d delay 0x%0h",
                       out_beat.channel, out_beat.delay_us);
                fail_cnt++;
            end else begin
                want = delay_reports.pop_front();
                compare_field("all_triggered", 32'(want.all_triggered),
                              32'(out_beat.all_triggered));
                compare_field("channel", 32'(want.channel), 32'(out_beat.channel));
                compare_field("delay_us", want.delay_us, out_beat.delay_us);
                compare_field("expired_mask", 32'(want.expired_mask),
                              32'(out_beat.expired_mask));
                compare_field("last", 32'(want.last), 32'(out_beat.last));
            end
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [PIN_W-1:0] pins,
                             input logic [NOW_W-1:0] now);
        t_in item;
        item.func       = func;
        item.pin_levels = pins;
        item.now_us     = now;
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        apply_capture_item(item);
    endtask

    // Drop valid, wait for every expected beat, then let a trailing item finish
    task automatic drain_reports();
        @(negedge clk);
        in_valid <= 1'b0;
        while (delay_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CHANNELS) cfg_channels = value[CNTC_W-1:0];
        else if (idx == REG_TIMEOUT) cfg_timeout = value;
    endtask

    function automatic logic [NOW_W-1:0] time_step();
        case ($urandom_range(9))
            0: return $urandom();   // jump anywhere, wrap included
            1: return '0;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    task automatic test_empty_check();
        send_item(FUNC_CHECK, 8'h00, 32'd0);
        drain_reports();
    endtask

    task automatic test_first_edge_capture();
        send_item(FUNC_SAMPLE, 8'h00, 32'd10);
        send_item(FUNC_SAMPLE, 8'h01, 32'hFFFF_FFF0);
        send_item(FUNC_SAMPLE, 8'h0F, 32'h0000_0005);
        send_item(FUNC_SAMPLE, 8'h0E, 32'h0000_0007);
        // second rising edge on a channel that already holds its arrival
        send_item(FUNC_SAMPLE, 8'h0F, 32'h0000_0009);
        send_item(FUNC_SAMPLE, 8'hFF, 32'h0000_0010);
        // earliest is 5, so channel 0 reports a wrapped delay
        send_item(FUNC_CHECK, 8'hAA, 32'h0000_0020);
        drain_reports();
    endtask

    task automatic test_pins_ignored();
        send_item(FUNC_CLEAR, 8'h00, 32'd100);
        send_item(FUNC_SAMPLE, 8'hFF, 32'd110);
        send_item(FUNC_CHECK, 8'h00, 32'd120);
        send_item(FUNC_NONE, 8'h00, 32'hFFFF_FFFF);
        // levels stay high across check and unused items: still no edge
        send_item(FUNC_SAMPLE, 8'hFF, 32'd130);
        send_item(FUNC_CHECK, 8'h55, 32'd140);
        drain_reports();
    endtask

    task automatic test_timeout_limit();
        write_reg(REG_CHANNELS, 32'd2);
        write_reg(REG_TIMEOUT, 32'd100);
        send_item(FUNC_SAMPLE, 8'h00, 32'd0);
        send_item(FUNC_SAMPLE, 8'h01, 32'd1000);
        send_item(FUNC_SAMPLE, 8'hF3, 32'd1100);
        // channel 0 is past the limit, channel 1 sits exactly on it and survives
        send_item(FUNC_CHECK, 8'h00, 32'd1200);
        drain_reports();
    endtask

    task automatic test_channel_count();
        write_reg(REG_CHANNELS, 32'd0);
        write_reg(REG_TIMEOUT, 32'd0);
        send_item(FUNC_CLEAR, 8'hFF, 32'd4000);
        send_item(FUNC_SAMPLE, 8'h00, 32'd4500);
        send_item(FUNC_SAMPLE, 8'h01, 32'd5000);
        send_item(FUNC_CHECK, 8'h00, 32'd5000);
        drain_reports();
        write_reg(REG_CHANNELS, 32'd15);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        send_item(FUNC_CHECK, 8'h00, 32'd6000);
        send_item(FUNC_SAMPLE, 8'hFE, 32'd7);
        send_item(FUNC_CHECK, 8'h00, 32'd3);
        drain_reports();
    endtask

    task automatic test_random_traffic();
        int unsigned      sent;
        int unsigned      burst;
        logic [PIN_W-1:0] levels;
        logic [NOW_W-1:0] now;
        logic [CFG_W-1:0] cfg_value;
        sent = 0;
        now  = $urandom();
        while (sent < RANDOM_ITEMS) begin
            // one long stretch with no idling on either side
            if (sent >= 90 && sent < 150) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 14;
                out_idle_pct = 14;
            end
            if ($urandom_range(3) == 0) begin
                drain_reports();
                if ($urandom_range(1)) begin
                    // mostly in range, sometimes with junk in the upper data bits
                    cfg_value = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(15);
                    write_reg(REG_CHANNELS, cfg_value);
                end else begin
                    case ($urandom_range(5))
                        0: cfg_value = '0;
                        1: cfg_value = '1;
                        2: cfg_value = TIMEOUT_RESET;
                        3: cfg_value = $urandom();
                        default: cfg_value = $urandom_range(20, 3000);
                    endcase
                    write_reg(REG_TIMEOUT, cfg_value);
                end
            end
            if ($urandom_range(1)) begin
                send_item(FUNC_CLEAR, PIN_W'($urandom()), now);
                sent++;
            end
            levels = '0;
            burst  = $urandom_range(1, 10);
            repeat (burst) begin
                now    = now + time_step();
                levels = ($urandom_range(4) == 0) ? PIN_W'($urandom())
                                                  : (levels | PIN_W'($urandom()));
                send_item(FUNC_SAMPLE, levels, now);
                sent++;
            end
            repeat ($urandom_range(1, 2)) begin
                now = now + time_step();
                send_item(FUNC_CHECK, PIN_W'($urandom()), now);
                sent++;
            end
            // stray item with every field random
            if ($urandom_range(7) == 0) begin
                send_item(2'($urandom()), PIN_W'($urandom()), $urandom());
                sent++;
            end
        end
        drain_reports();
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_check();
        test_first_edge_capture();
        test_pins_ignored();
        test_timeout_limit();
        test_channel_count();
        test_random_traffic();
        if (fail_cnt == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
